>>> rtl/bmc_pkg.sv
package bmc_pkg;

    // Bracket kinds as held on the stack.
    typedef logic [1:0] kind_t;

    // Line status codes reported with each result.
    typedef enum logic [1:0] {
        STATUS_COMPLETE   = 2'd0,
        STATUS_INCOMPLETE = 2'd1,
        STATUS_CORRUPTED  = 2'd2,
        STATUS_OVERFLOW   = 2'd3
    } status_t;

    // Stack operation broadcast to every cell of the chain.
    typedef struct packed {
        logic push;
        logic pop;
    } stack_op_t;

    // Result of decoding one character as an opener or a closer.
    typedef struct packed {
        logic  hit;
        kind_t kind;
    } kind_info_t;

    localparam kind_t KIND_PAREN = 2'd0;
    localparam kind_t KIND_SQUARE = 2'd1;
    localparam kind_t KIND_CURLY = 2'd2;
    localparam kind_t KIND_ANGLE = 2'd3;

    localparam logic [7:0] CHAR_OPEN_PAREN = 8'h28;
    localparam logic [7:0] CHAR_OPEN_SQUARE = 8'h5B;
    localparam logic [7:0] CHAR_OPEN_CURLY = 8'h7B;
    localparam logic [7:0] CHAR_OPEN_ANGLE = 8'h3C;
    localparam logic [7:0] CHAR_CLOSE_PAREN = 8'h29;
    localparam logic [7:0] CHAR_CLOSE_SQUARE = 8'h5D;
    localparam logic [7:0] CHAR_CLOSE_CURLY = 8'h7D;
    localparam logic [7:0] CHAR_CLOSE_ANGLE = 8'h3E;

    localparam int POINTS_W = 15;
    localparam logic [POINTS_W-1:0] POINTS_PAREN = 15'd3;
    localparam logic [POINTS_W-1:0] POINTS_SQUARE = 15'd57;
    localparam logic [POINTS_W-1:0] POINTS_CURLY = 15'd1197;
    localparam logic [POINTS_W-1:0] POINTS_ANGLE = 15'd25137;

    function automatic kind_info_t opener_decode(input logic [7:0] c);
        kind_info_t info;
        info = '0;
        case (c)
            CHAR_OPEN_PAREN:  info = '{hit: 1'b1, kind: KIND_PAREN};
            CHAR_OPEN_SQUARE: info = '{hit: 1'b1, kind: KIND_SQUARE};
            CHAR_OPEN_CURLY:  info = '{hit: 1'b1, kind: KIND_CURLY};
            CHAR_OPEN_ANGLE:  info = '{hit: 1'b1, kind: KIND_ANGLE};
            default:          info = '0;
        endcase
        return info;
    endfunction

    function automatic kind_info_t closer_decode(input logic [7:0] c);
        kind_info_t info;
        info = '0;
        case (c)
            CHAR_CLOSE_PAREN:  info = '{hit: 1'b1, kind: KIND_PAREN};
            CHAR_CLOSE_SQUARE: info = '{hit: 1'b1, kind: KIND_SQUARE};
            CHAR_CLOSE_CURLY:  info = '{hit: 1'b1, kind: KIND_CURLY};
            CHAR_CLOSE_ANGLE:  info = '{hit: 1'b1, kind: KIND_ANGLE};
            default:           info = '0;
        endcase
        return info;
    endfunction

    function automatic logic [POINTS_W-1:0] closer_points(input logic [7:0] c);
        logic [POINTS_W-1:0] pts;
        pts = '0;
        case (c)
            CHAR_CLOSE_PAREN:  pts = POINTS_PAREN;
            CHAR_CLOSE_SQUARE: pts = POINTS_SQUARE;
            CHAR_CLOSE_CURLY:  pts = POINTS_CURLY;
            CHAR_CLOSE_ANGLE:  pts = POINTS_ANGLE;
            default:           pts = '0;
        endcase
        return pts;
    endfunction

endpackage

>>> rtl/bracket_match_checker.sv
// Bracket match checker: checks lines of text for balanced brackets.
// The input channel (in_valid/in_ready) carries one character per transfer,
// with end_of_line marking the last character of a line. Openers ( [ { < are
// pushed, matching closers pop, and the first mismatch marks the line
// corrupted. Other characters are ignored.
// The output channel (out_valid/out_ready) carries one result per line: the
// status, the illegal character, its points and the saturating running total.
// Throughput is one character per cycle while no result is held at the output:
// the stack is a row of shift cells whose top sits in cell 0, so a push or pop is one shift.
// The result of a line appears in the cycle after its last character transfers.
// A result waiting in the output register blocks every character: a new
// transfer is taken only when the output register is empty or is being
// drained in the same cycle.
// While the receiver stalls with a result pending, in_ready stays low.
// Reset clears the line state, the running total and the output valid flag;
// output payload and stack cell contents are not reset since only loaded entries are read.
module bracket_match_checker #(
    parameter int STACK_DEPTH = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  char_code,
    input  logic        end_of_line,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  line_status,
    output logic [7:0]  illegal_char,
    output logic [14:0] line_points,
    output logic [31:0] total_points
);

    localparam int LEVEL_W = $clog2(STACK_DEPTH + 1);
    localparam logic [LEVEL_W-1:0] LEVEL_FULL = LEVEL_W'(STACK_DEPTH);

    logic [LEVEL_W-1:0] level_reg, level_next;
    logic               bad_reg, bad_next;
    logic               ovf_reg, ovf_next;
    logic [7:0]         first_bad_reg, first_bad_next;
    logic [31:0]        score_reg, score_next;
    logic               out_valid_reg, out_valid_next;
    bmc_pkg::status_t   status_reg, status_next;
    logic [7:0]         illegal_reg, illegal_next;
    logic [14:0]        points_reg, points_next;

    logic                accept;
    logic                active;
    bmc_pkg::kind_info_t open_info;
    bmc_pkg::kind_info_t close_info;
    bmc_pkg::kind_t      top_kind;
    bmc_pkg::stack_op_t  op;
    logic                full;
    logic                pop_match;
    logic                ovf_set;
    logic                bad_set;
    logic [LEVEL_W-1:0]  level_now;
    logic                bad_now;
    logic                ovf_now;
    logic [7:0]          char_now;
    logic [14:0]         pts_now;
    logic [32:0]         score_sum;

    // Handshake: take a character whenever the output register can take a result.
    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    // Character decode and stack decision against the current top.
    assign active     = !bad_reg && !ovf_reg;
    assign open_info  = bmc_pkg::opener_decode(char_code);
    assign close_info = bmc_pkg::closer_decode(char_code);
    assign full       = (level_reg == LEVEL_FULL);
    assign pop_match  = active && close_info.hit && (level_reg != '0)
                        && (top_kind == close_info.kind);
    assign ovf_set    = active && open_info.hit && full;
    assign bad_set    = active && close_info.hit && !pop_match;
    assign op.push    = accept && active && open_info.hit && !full;
    assign op.pop     = accept && pop_match;

    bmc_stack #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_stack (
        .clk       (clk),
        .op        (op),
        .push_kind (open_info.kind),
        .top_kind  (top_kind)
    );

    // Line state after this character.
    always_comb
    begin
        level_now = level_reg;
        if (op.push)
        begin
            level_now = level_reg + LEVEL_W'(1);
        end
        else if (op.pop)
        begin
            level_now = level_reg - LEVEL_W'(1);
        end
        bad_now  = bad_reg || bad_set;
        ovf_now  = ovf_reg || ovf_set;
        char_now = bad_set ? char_code : first_bad_reg;
        pts_now  = bad_now ? bmc_pkg::closer_points(char_now) : '0;
    end

    // Saturating running total.
    assign score_sum = {1'b0, score_reg} + 33'(pts_now);

    // Line result for a final character.
    always_comb
    begin
        if (bad_now)
        begin
            status_next = bmc_pkg::STATUS_CORRUPTED;
        end
        else if (ovf_now)
        begin
            status_next = bmc_pkg::STATUS_OVERFLOW;
        end
        else if (level_now != '0)
        begin
            status_next = bmc_pkg::STATUS_INCOMPLETE;
        end
        else
        begin
            status_next = bmc_pkg::STATUS_COMPLETE;
        end
        illegal_next = bad_now ? char_now : '0;
        points_next  = pts_now;
    end

    // Next values of the line and output control state.
    always_comb
    begin
        level_next     = level_reg;
        bad_next       = bad_reg;
        ovf_next       = ovf_reg;
        first_bad_next = first_bad_reg;
        score_next     = score_reg;
        out_valid_next = out_valid_reg && !out_ready;
        if (accept)
        begin
            if (end_of_line)
            begin
                level_next     = '0;
                bad_next       = 1'b0;
                ovf_next       = 1'b0;
                first_bad_next = '0;
                score_next     = score_sum[32] ? 32'hFFFF_FFFF : score_sum[31:0];
                out_valid_next = 1'b1;
            end
            else
            begin
                level_next     = level_now;
                bad_next       = bad_now;
                ovf_next       = ovf_now;
                first_bad_next = char_now;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg     <= '0;
            bad_reg       <= 1'b0;
            ovf_reg       <= 1'b0;
            first_bad_reg <= '0;
            score_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            level_reg     <= level_next;
            bad_reg       <= bad_next;
            ovf_reg       <= ovf_next;
            first_bad_reg <= first_bad_next;
            score_reg     <= score_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output payload registers load with each final character.
    always_ff @(posedge clk)
    begin
        if (accept && end_of_line)
        begin
            status_reg  <= status_next;
            illegal_reg <= illegal_next;
            points_reg  <= points_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign line_status  = status_reg;
    assign illegal_char = illegal_reg;
    assign line_points  = points_reg;
    assign total_points = score_reg;

    // A line never ends up both corrupted and overflowed.
    assert property (@(posedge clk) disable iff (!rst_n) !(bad_reg && ovf_reg))
        else $error("line marked both corrupted and overflowed");

    // The stack level never exceeds the number of cells.
    assert property (@(posedge clk) disable iff (!rst_n) level_reg <= LEVEL_FULL)
        else $error("stack level beyond depth");

    // A final character yields a result in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && end_of_line |=> out_valid)
        else $error("missing result after end of line");

    // Nonzero points are reported only for corrupted lines.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (line_points != '0) |-> (line_status == bmc_pkg::STATUS_CORRUPTED))
        else $error("points on a line that is not corrupted");

endmodule

>>> rtl/bmc_cell.sv
module bmc_cell (
    input  logic              clk,
    input  bmc_pkg::stack_op_t op,
    input  bmc_pkg::kind_t    from_above,
    input  bmc_pkg::kind_t    from_below,
    output bmc_pkg::kind_t    kind
);

    bmc_pkg::kind_t kind_reg;
    bmc_pkg::kind_t kind_next;

    // A push moves every entry one cell deeper; a pop moves it one cell up.
    always_comb
    begin
        kind_next = kind_reg;
        if (op.push)
        begin
            kind_next = from_above;
        end
        else if (op.pop)
        begin
            kind_next = from_below;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
    end

    assign kind = kind_reg;

endmodule

>>> rtl/bmc_stack.sv
module bmc_stack #(
    parameter int STACK_DEPTH = 64
) (
    input  logic              clk,
    input  bmc_pkg::stack_op_t op,
    input  bmc_pkg::kind_t    push_kind,
    output bmc_pkg::kind_t    top_kind
);

    bmc_pkg::kind_t kinds [STACK_DEPTH];

    // Row of cells; cell 0 always holds the top of the stack.
    for (genvar i = 0; i < STACK_DEPTH; i++)
    begin : g_cell
        bmc_pkg::kind_t above;
        bmc_pkg::kind_t below;

        if (i == 0)
        begin : g_first
            assign above = push_kind;
        end
        else
        begin : g_inner_above
            assign above = kinds[i-1];
        end

        if (i == STACK_DEPTH - 1)
        begin : g_last
            assign below = '0;
        end
        else
        begin : g_inner_below
            assign below = kinds[i+1];
        end

        bmc_cell u_cell (
            .clk        (clk),
            .op         (op),
            .from_above (above),
            .from_below (below),
            .kind       (kinds[i])
        );
    end

    assign top_kind = kinds[0];

endmodule
